>>> rtl/scaled_moving_average_unit_macros.svh
// Assertion macros shared by the scaled moving average unit.
// Expects clk and rst (synchronous, active high) in the using module.
`ifndef SCALED_MOVING_AVERAGE_UNIT_MACROS_SVH
`define SCALED_MOVING_AVERAGE_UNIT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define SMAU_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SMAU_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SMAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/smau_pkg.sv
// Package for the scaled moving average unit: payload types, register codes,
// state encodings and fixed widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smau_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int AVG_W       = 32;
  localparam int COUNT_W     = 7;
  localparam int SCALE_W     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int ROUND_SHIFT = FRAC_BITS - 1;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FILTER_ENABLE = 1'b0,
    REG_SCALE_FACTOR  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [AVG_W-1:0]   average;
    logic [COUNT_W-1:0] sample_count;
  } out_item_t;

  typedef enum logic {
    F_IDLE,
    F_UPDATE
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

>>> rtl/smau_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload types come from smau_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface smau_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/smau_front.sv
// Front end: accepts samples, keeps the sample ring, running sum, fill count
// and write index, and pushes (sum, count) pairs to the queue. Uses smau_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "scaled_moving_average_unit_macros.svh"

module smau_front import smau_pkg::*; #(
  parameter int WINDOW_LEN = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic filter_enable,
  smau_stream_if.sink samples,
  output logic push_valid,
  input  logic push_ready,
  output logic [$clog2(WINDOW_LEN*65535+1)+$clog2(WINDOW_LEN+1)-1:0] push_data
);

  localparam int SUM_W = $clog2(WINDOW_LEN*65535+1);
  localparam int CNT_W = $clog2(WINDOW_LEN+1);
  localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(WINDOW_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(WINDOW_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_AFTER_ZERO = (WINDOW_LEN > 1) ? IDX_W'(1) : '0;

  front_state_t        state, state_next;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SUM_W-1:0]    running_sum, sum_next;
  logic [CNT_W-1:0]    fill_count, fill_next;
  logic [IDX_W-1:0]    write_index, index_next, index_adv;
  logic [SAMPLE_W-1:0] ring [WINDOW_LEN];
  logic [SAMPLE_W-1:0] oldest;
  logic                ring_we;
  logic [IDX_W-1:0]    ring_waddr;

  assign index_adv = (write_index == IDX_LAST) ? '0 : write_index + IDX_W'(1);
  assign push_data = {sum_next, fill_next};

  always_comb begin
    state_next    = state;
    samples.ready = (state == F_IDLE);
    push_valid    = 1'b0;
    ring_we       = 1'b0;
    ring_waddr    = write_index;
    sum_next      = running_sum;
    fill_next     = fill_count;
    index_next    = write_index;
    case (state)
      F_IDLE: begin
        if (samples.valid) state_next = F_UPDATE;
      end
      F_UPDATE: begin
        if (!filter_enable) begin
          // pass-through: the sample alone is the window
          ring_waddr = '0;
          sum_next   = SUM_W'(sample_q);
          fill_next  = CNT_W'(1);
          index_next = IDX_AFTER_ZERO;
        end else if (fill_count < CNT_FULL) begin
          sum_next   = running_sum + SUM_W'(sample_q);
          fill_next  = fill_count + CNT_W'(1);
          index_next = index_adv;
        end else begin
          // swap the oldest entry for the new sample
          sum_next   = SUM_W'({1'b0, running_sum} + (SUM_W+1)'(sample_q)
                              - (SUM_W+1)'(oldest));
          index_next = index_adv;
        end
        push_valid = 1'b1;
        if (push_ready) begin
          ring_we    = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      running_sum <= '0;
      fill_count  <= '0;
      write_index <= '0;
    end else begin
      state <= state_next;
      if (ring_we) begin
        running_sum <= sum_next;
        fill_count  <= fill_next;
        write_index <= index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) sample_q <= samples.data.sample;
  end

  // ring memory: one write port, one registered read at the write index
  always_ff @(posedge clk) begin
    if (ring_we) ring[ring_waddr] <= sample_q;
    oldest <= ring[write_index];
  end

  `SMAU_ASSERT_HOLDS(a_fill_bound, fill_count <= CNT_FULL, "fill count above window")
  `SMAU_ASSERT_HOLDS(a_index_bound, int'(write_index) < WINDOW_LEN, "write index out of ring")
  `SMAU_ASSERT_NEXT(a_full_stays, state == F_UPDATE && push_ready && filter_enable && fill_count == CNT_FULL, fill_count == CNT_FULL, "full window lost its count")

endmodule

`default_nettype wire

>>> rtl/smau_queue.sv
// Two-entry queue between the front end and the divider back end.
// Uses smau_pkg for the depth.
`timescale 1ns / 1ps
`default_nettype none

module smau_queue import smau_pkg::*; #(
  parameter int WIDTH = 28
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [LVL_W-1:0] level;
  logic             do_push, do_pop;

  assign push_ready = (level != LVL_W'(QUEUE_DEPTH));
  assign pop_valid  = (level != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      level <= level + LVL_W'(1);
      else if (do_pop && !do_push) level <= level - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

>>> rtl/smau_back.sv
// Back end: scales the running sum, divides by the fill count one quotient
// bit per cycle, saturates and holds the result beat. Uses smau_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "scaled_moving_average_unit_macros.svh"

module smau_back import smau_pkg::*; #(
  parameter int WINDOW_LEN = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic [SCALE_W-1:0] scale_factor,
  input  logic pop_valid,
  output logic pop_ready,
  input  logic [$clog2(WINDOW_LEN*65535+1)+$clog2(WINDOW_LEN+1)-1:0] pop_data,
  smau_stream_if.source results
);

  localparam int SUM_W  = $clog2(WINDOW_LEN*65535+1);
  localparam int CNT_W  = $clog2(WINDOW_LEN+1);
  localparam int NUM_W  = SUM_W + SCALE_W + 1;
  localparam int QUO_W  = NUM_W - FRAC_BITS;
  localparam int STEP_W = $clog2(QUO_W);

  back_state_t       state, state_next;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NUM_W-1:0]  numer;
  logic [QUO_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    rem_sh, rem_diff;
  logic              take_bit;
  logic              out_valid;
  out_item_t         out_item;
  logic [AVG_W-1:0]  avg_sat;

  assign numer    = NUM_W'(sum_q) * NUM_W'(scale_factor) + (NUM_W'(cnt_q) << ROUND_SHIFT);
  assign rem_sh   = {rem, quo[QUO_W-1]};
  assign rem_diff = rem_sh - {1'b0, cnt_q};
  assign take_bit = (rem_sh >= {1'b0, cnt_q});
  assign avg_sat  = (quo[QUO_W-1:AVG_W] != '0) ? '1 : quo[AVG_W-1:0];

  assign results.valid = out_valid;
  assign results.data  = out_item;

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    case (state)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) state_next = B_MUL;
      end
      B_MUL:  state_next = B_DIV;
      B_DIV:  if (step == '0) state_next = B_DONE;
      B_DONE: if (!out_valid || results.ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_DONE && (!out_valid || results.ready)) out_valid <= 1'b1;
      else if (results.ready)                                 out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop_valid) {sum_q, cnt_q} <= pop_data;
      end
      B_MUL: begin
        // drop the fraction bits now, then divide by the count alone
        quo  <= numer[NUM_W-1:FRAC_BITS];
        rem  <= '0;
        step <= STEP_W'(QUO_W - 1);
      end
      B_DIV: begin
        quo  <= {quo[QUO_W-2:0], take_bit};
        rem  <= take_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        step <= step - STEP_W'(1);
      end
      B_DONE: begin
        if (!out_valid || results.ready) begin
          out_item.average      <= avg_sat;
          out_item.sample_count <= COUNT_W'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  `SMAU_ASSERT_IMPLIES(a_div_nonzero, state == B_DIV, cnt_q != '0, "divide by zero count")
  `SMAU_ASSERT_IMPLIES(a_rem_bound, state == B_DIV, rem < cnt_q, "remainder not below divisor")
  `SMAU_ASSERT_IMPLIES(a_count_valid, out_valid, out_item.sample_count != '0, "result with empty window")

endmodule

`default_nettype wire

>>> rtl/scaled_moving_average_unit.sv
// Scaled moving average unit. A sample goes through the front end, the queue,
// the multiply state, the bit-serial divide steps and the output load to the
// result beat. The back end takes a new queue entry only after loading its last
// result, so the divider sets sustained throughput. Reset clears control state,
// running sum, fill count, write index and config, but not the data registers;
// ring entries are read only after being written.
`timescale 1ns / 1ps
`default_nettype none

module scaled_moving_average_unit import smau_pkg::*; #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  smau_stream_if.sink            samples,
  smau_stream_if.source          results
);

  localparam int SUM_W   = $clog2(WINDOW_LEN*65535+1);
  localparam int CNT_W   = $clog2(WINDOW_LEN+1);
  localparam int ENTRY_W = SUM_W + CNT_W;

  logic               filter_enable;
  logic [SCALE_W-1:0] scale_factor;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0] push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b1;
      scale_factor  <= SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        REG_SCALE_FACTOR:  scale_factor  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  smau_front #(.WINDOW_LEN(WINDOW_LEN)) u_front (
    .clk           (clk),
    .rst           (rst),
    .filter_enable (filter_enable),
    .samples       (samples),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  smau_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  smau_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
    .clk          (clk),
    .rst          (rst),
    .scale_factor (scale_factor),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .results      (results)
  );

endmodule

`default_nettype wire
